// ----- hw/rtl/lls_pkg.sv -----
// Shared types, token kinds and character helpers for the token scanner.
package lls_pkg;

   localparam int OFFSET_BITS_DEF     = 20;
   localparam int LINE_BITS_DEF       = 16;
   localparam int KEYWORD_MAX_LEN_DEF = 6;

   localparam int QUEUE_DEPTH = 8;
   localparam int MAX_PUSH    = 3;

   localparam logic [5:0] K_LEFT_PAREN  = 6'd0;
   localparam logic [5:0] K_RIGHT_PAREN = 6'd1;
   localparam logic [5:0] K_LEFT_BRACE  = 6'd2;
   localparam logic [5:0] K_RIGHT_BRACE = 6'd3;
   localparam logic [5:0] K_COMMA       = 6'd4;
   localparam logic [5:0] K_DOT         = 6'd5;
   localparam logic [5:0] K_MINUS       = 6'd6;
   localparam logic [5:0] K_PLUS        = 6'd7;
   localparam logic [5:0] K_SEMICOLON   = 6'd8;
   localparam logic [5:0] K_SLASH       = 6'd9;
   localparam logic [5:0] K_STAR        = 6'd10;
   localparam logic [5:0] K_BANG        = 6'd11;
   localparam logic [5:0] K_EQUAL       = 6'd13;
   localparam logic [5:0] K_GREATER     = 6'd15;
   localparam logic [5:0] K_LESS        = 6'd17;
   localparam logic [5:0] K_IDENT       = 6'd19;
   localparam logic [5:0] K_STRING      = 6'd20;
   localparam logic [5:0] K_NUMBER      = 6'd21;
   localparam logic [5:0] K_KW_BASE     = 6'd22;
   localparam logic [5:0] K_EOF         = 6'd38;
   localparam logic [5:0] K_BADCHAR     = 6'd39;
   localparam logic [5:0] K_UNTERM      = 6'd40;

   // keywords, right aligned, in kind order
   localparam logic [63:0] KW_TEXT [16] = '{
      64'("and"), 64'("class"), 64'("else"), 64'("false"),
      64'("fun"), 64'("for"), 64'("if"), 64'("nil"),
      64'("or"), 64'("print"), 64'("return"), 64'("super"),
      64'("this"), 64'("true"), 64'("var"), 64'("while")
   };

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_marker;
   } req_item_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [19:0] start_offset;
      logic [19:0] token_length;
      logic [15:0] line_number;
      logic        last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                  count;
      rsp_item_type [MAX_PUSH-1:0] item;
   } push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   function automatic logic [5:0] kw_kind(input logic [63:0] word);
      logic [5:0] k;
      k = K_IDENT;
      for (int i = 15; i >= 0; i--) begin
         if (word == KW_TEXT[i]) k = K_KW_BASE + 6'(i);
      end
      return k;
   endfunction

   function automatic logic [5:0] op_single(input logic [7:0] p);
      logic [5:0] k;
      unique case (p)
         "!":     k = K_BANG;
         "=":     k = K_EQUAL;
         ">":     k = K_GREATER;
         "<":     k = K_LESS;
         default: k = K_SLASH;
      endcase
      return k;
   endfunction

endpackage

// ----- hw/rtl/lls_scan.sv -----
// Scanner state and per-byte token generation, up to three tokens per item.
module lls_scan #(
   parameter int OFFSET_BITS     = lls_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS       = lls_pkg::LINE_BITS_DEF,
   parameter int KEYWORD_MAX_LEN = lls_pkg::KEYWORD_MAX_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  lls_pkg::req_item_type req_data,
   output lls_pkg::push_type     push
);
   import lls_pkg::*;

   localparam int PW = 8 * KEYWORD_MAX_LEN;
   localparam logic [OFFSET_BITS-1:0] LEN_MAX  = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

   typedef enum logic [3:0] {
      M_IDLE, M_OP, M_COMMENT, M_STRING, M_INT, M_DOT, M_FRAC, M_IDENT
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] tstart_ff, tstart_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [PW-1:0]          prefix_ff, prefix_in;
   logic [7:0]             pend_ff, pend_in;
   logic [OFFSET_BITS-1:0] len_ff, len_in;

   logic                   f1_v, f2_v, t_v, do_flush, do_start, is_eof;
   logic [5:0]             f1_kind, t_kind;
   logic [OFFSET_BITS-1:0] f1_len, t_start, t_len, len_sat;
   logic [LINE_BITS-1:0]   line_inc;
   logic [7:0]             c;
   logic [1:0]             nf, cnt;
   rsp_item_type [MAX_PUSH-1:0] toks;

   always_comb begin
      c         = req_data.source_byte;
      mode_in   = mode_ff;
      tstart_in = tstart_ff;
      pos_in    = pos_ff + 1'b1;
      line_in   = line_ff;
      prefix_in = prefix_ff;
      pend_in   = pend_ff;
      len_in    = len_ff;
      f1_v = 1'b0; f2_v = 1'b0; t_v = 1'b0;
      f1_kind = K_NUMBER; f1_len = len_ff;
      t_kind = K_EOF; t_start = pos_ff; t_len = '0;
      do_flush = 1'b0; do_start = 1'b0; is_eof = 1'b0;
      len_sat  = (len_ff < LEN_MAX) ? len_ff + 1'b1 : len_ff;
      line_inc = (line_ff < LINE_MAX) ? line_ff + 1'b1 : line_ff;

      if (req_data.end_marker) begin
         is_eof = 1'b1;
         if (mode_ff == M_STRING) begin
            f1_v = 1'b1; f1_kind = K_UNTERM;
         end else begin
            do_flush = 1'b1;
         end
         t_v = 1'b1;
      end else begin
         unique case (mode_ff)
            M_OP: begin
               if (pend_ff == "/" && c == "/") begin
                  mode_in = M_COMMENT;
               end else if (pend_ff != "/" && c == "=") begin
                  t_v = 1'b1; t_kind = op_single(pend_ff) + 6'd1;
                  t_start = tstart_ff; t_len = OFFSET_BITS'(2);
                  mode_in = M_IDLE;
               end else begin
                  do_flush = 1'b1; do_start = 1'b1;
               end
            end
            M_COMMENT: begin
               if (c == "\n") begin
                  mode_in = M_IDLE; line_in = line_inc;
               end
            end
            M_STRING: begin
               len_in = len_sat;
               if (c == "\"") begin
                  t_v = 1'b1; t_kind = K_STRING; t_start = tstart_ff; t_len = len_sat;
                  mode_in = M_IDLE;
               end else if (c == "\n") begin
                  line_in = line_inc;
               end
            end
            M_INT: begin
               if (is_digit(c)) len_in = len_sat;
               else if (c == ".") mode_in = M_DOT;
               else begin do_flush = 1'b1; do_start = 1'b1; end
            end
            M_DOT: begin
               if (is_digit(c)) begin
                  len_in  = (len_sat < LEN_MAX) ? len_sat + 1'b1 : len_sat;
                  mode_in = M_FRAC;
               end else begin
                  do_flush = 1'b1; do_start = 1'b1;
               end
            end
            M_FRAC: begin
               if (is_digit(c)) len_in = len_sat;
               else begin do_flush = 1'b1; do_start = 1'b1; end
            end
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  if (len_ff < OFFSET_BITS'(KEYWORD_MAX_LEN))
                     prefix_in = {prefix_ff[PW-9:0], c};
                  len_in = len_sat;
               end else begin
                  do_flush = 1'b1; do_start = 1'b1;
               end
            end
            default: do_start = 1'b1;
         endcase
      end

      if (do_flush) begin
         unique case (mode_ff) inside
            M_OP: begin
               f1_v = 1'b1; f1_kind = op_single(pend_ff); f1_len = OFFSET_BITS'(1);
            end
            M_INT, M_FRAC: f1_v = 1'b1;
            M_DOT: begin
               f1_v = 1'b1; f2_v = 1'b1;
            end
            M_IDENT: begin
               f1_v = 1'b1;
               f1_kind = (len_ff <= OFFSET_BITS'(KEYWORD_MAX_LEN)) ?
                         kw_kind(64'(prefix_ff)) : K_IDENT;
            end
            default: f1_v = 1'b0;
         endcase
      end

      if (do_start) begin
         mode_in   = M_IDLE;
         tstart_in = pos_ff;
         len_in    = OFFSET_BITS'(1);
         t_start   = pos_ff;
         t_len     = OFFSET_BITS'(1);
         unique case (c) inside
            "(": begin t_v = 1'b1; t_kind = K_LEFT_PAREN; end
            ")": begin t_v = 1'b1; t_kind = K_RIGHT_PAREN; end
            "{": begin t_v = 1'b1; t_kind = K_LEFT_BRACE; end
            "}": begin t_v = 1'b1; t_kind = K_RIGHT_BRACE; end
            ",": begin t_v = 1'b1; t_kind = K_COMMA; end
            ".": begin t_v = 1'b1; t_kind = K_DOT; end
            "-": begin t_v = 1'b1; t_kind = K_MINUS; end
            "+": begin t_v = 1'b1; t_kind = K_PLUS; end
            ";": begin t_v = 1'b1; t_kind = K_SEMICOLON; end
            "*": begin t_v = 1'b1; t_kind = K_STAR; end
            "!", "=", "<", ">", "/": begin
               mode_in = M_OP; pend_in = c;
            end
            " ", "\r", "\t": t_v = 1'b0;
            "\n": line_in = line_inc;
            "\"": mode_in = M_STRING;
            default: begin
               if (is_digit(c)) mode_in = M_INT;
               else if (is_alpha(c)) begin
                  mode_in = M_IDENT; prefix_in = PW'(c);
               end else begin
                  t_v = 1'b1; t_kind = K_BADCHAR;
               end
            end
         endcase
      end

      if (is_eof) begin
         mode_in = M_IDLE; tstart_in = '0; pos_in = '0; line_in = LINE_BITS'(1);
         prefix_in = '0; pend_in = '0; len_in = '0;
      end

      // pack candidates in order: flushed token, trailing dot, new token
      toks = '0;
      toks[0].kind = f1_kind;
      toks[0].start_offset = 20'(tstart_ff);
      toks[0].token_length = 20'(f1_len);
      toks[0].line_number  = 16'(line_ff);
      toks[1].kind = K_DOT;
      toks[1].start_offset = 20'(pos_ff - 1'b1);
      toks[1].token_length = 20'd1;
      toks[1].line_number  = 16'(line_ff);
      nf = {1'b0, f1_v} + {1'b0, f2_v};
      if (t_v) begin
         toks[nf].kind         = t_kind;
         toks[nf].start_offset = 20'(t_start);
         toks[nf].token_length = 20'(t_len);
         toks[nf].line_number  = is_eof ? 16'd0 : 16'(line_ff);
      end
      cnt = nf + {1'b0, t_v};
      for (int i = 0; i < MAX_PUSH; i++) begin
         toks[i].last_of_run = (2'(i) == cnt - 2'd1);
      end
      push.item  = toks;
      push.count = accept ? cnt : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         tstart_ff <= '0;
         pos_ff    <= '0;
         line_ff   <= LINE_BITS'(1);
         prefix_ff <= '0;
         pend_ff   <= '0;
         len_ff    <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         tstart_ff <= tstart_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         prefix_ff <= prefix_in;
         pend_ff   <= pend_in;
         len_ff    <= len_in;
      end
   end

endmodule

// ----- hw/rtl/lls_fifo.sv -----
// Token queue: takes up to three items per cycle, hands out one per cycle while rsp_stall is low.
module lls_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  lls_pkg::push_type     push,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lls_pkg::rsp_item_type rsp_data
);
   import lls_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   rsp_item_type       mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     count_ff, count_in;
   logic               pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // room for a worst-case burst must exist before an item is taken
   assign full      = (count_ff > (PTR_W+1)'(QUEUE_DEPTH - MAX_PUSH));
   assign count_in  = count_ff + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (2'(i) < push.count) mem_ff[wr_ptr_ff + PTR_W'(i)] <= push.item[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push.count);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/lox_lexer_token_scanner.sv -----
// Top level of the streaming token scanner: scan logic plus token queue.
//
//   channel | dir | handshake           | payload
//   req_    | in  | req_valid/req_stall | source_byte, end_marker
//   rsp_    | out | rsp_valid/rsp_stall | kind, start_offset, token_length,
//           |     |                     | line_number, last_of_run
//
// One byte is taken per cycle while req_stall is low; its tokens enter the queue at that
// edge and are handed out on rsp_ in order, one per cycle while rsp_stall is low.
// req_stall rises when the eight-entry queue has fewer than three free slots.
// Reset is synchronous: line 1, offset 0, queue empty. No clearing pass.
module lox_lexer_token_scanner #(
   parameter int OFFSET_BITS     = lls_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS       = lls_pkg::LINE_BITS_DEF,
   parameter int KEYWORD_MAX_LEN = lls_pkg::KEYWORD_MAX_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lls_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lls_pkg::rsp_item_type rsp_data
);
   import lls_pkg::*;

   logic     accept;
   push_type push;

   assign accept = req_valid && !req_stall;

   lls_scan #(
      .OFFSET_BITS(OFFSET_BITS),
      .LINE_BITS(LINE_BITS),
      .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req_data(req_data),
      .push(push)
   );

   lls_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

`ifndef SYNTHESIS
   a_eof_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.end_marker |-> push.count != 2'd0)
      else $error("end marker produced no token");
   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |-> push.count == 2'd0)
      else $error("token pushed without an accepted item");
   a_burst_limit: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> push.item[push.count - 2'd1].last_of_run)
      else $error("last token of item not marked");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("queue not empty after reset");
`endif

endmodule

// ----- tb/sv/lox_lexer_token_scanner_tb.sv -----
// Testbench for the streaming token scanner: directed sources, random programs, handshake idling.
`timescale 1ns / 1ps

module lox_lexer_token_scanner_tb;
   import lls_pkg::*;

   typedef enum logic [3:0] {
      SM_IDLE, SM_OP, SM_COMMENT, SM_STRING, SM_INT, SM_DOT, SM_FRAC, SM_IDENT
   } scan_state_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [19:0] OFS_MAX = 20'hFFFFF;
   localparam logic [15:0] LINE_MAX = 16'hFFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   lox_lexer_token_scanner u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   scan_state_type mode;
   logic [19:0] tok_start, byte_pos, lex_len;
   logic [15:0] line_cnt;
   logic [47:0] prefix;
   logic [7:0]  pend_op;

   rsp_item_type token_queue[$];
   rsp_item_type run_tokens[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 1'b0;
   int quiet_cycles = 0;

   task automatic lexer_reset();
      mode = SM_IDLE; tok_start = '0; byte_pos = '0; lex_len = '0;
      line_cnt = 16'd1; prefix = '0; pend_op = '0;
   endtask

   function automatic bit digit_c(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit alpha_c(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic [19:0] bump(logic [19:0] x);
      return (x < OFS_MAX) ? x + 20'd1 : x;
   endfunction

   function automatic logic [5:0] single_op_kind(logic [7:0] p);
      case (p)
         "!": return K_BANG;
         "=": return K_EQUAL;
         ">": return K_GREATER;
         "<": return K_LESS;
         default: return K_SLASH;
      endcase
   endfunction

   task automatic add_token(logic [5:0] k, logic [19:0] s, logic [19:0] l, logic [15:0] ln);
      rsp_item_type t;
      t.kind = k; t.start_offset = s; t.token_length = l; t.line_number = ln;
      t.last_of_run = 1'b0;
      if (run_tokens.size() < 3) run_tokens = {run_tokens, t};
   endtask

   task automatic line_inc();
      if (line_cnt < LINE_MAX) line_cnt++;
   endtask

   task automatic flush_lexeme(logic [19:0] pos);
      logic [5:0] k;
      case (mode) inside
         SM_OP: add_token(single_op_kind(pend_op), tok_start, 20'd1, line_cnt);
         SM_INT, SM_FRAC: add_token(K_NUMBER, tok_start, lex_len, line_cnt);
         SM_DOT: begin
            add_token(K_NUMBER, tok_start, lex_len, line_cnt);
            add_token(K_DOT, pos - 20'd1, 20'd1, line_cnt);
         end
         SM_IDENT: begin
            k = K_IDENT;
            if (lex_len <= 20'd6)
               for (int i = 15; i >= 0; i--)
                  if ({16'd0, prefix} == KW_TEXT[i]) k = K_KW_BASE + 6'(i);
            add_token(k, tok_start, lex_len, line_cnt);
         end
         default: ;
      endcase
      mode = SM_IDLE;
   endtask

   task automatic begin_lexeme(logic [7:0] c, logic [19:0] pos);
      mode = SM_IDLE; tok_start = pos; lex_len = 20'd1;
      case (c) inside
         "(": add_token(K_LEFT_PAREN, pos, 20'd1, line_cnt);
         ")": add_token(K_RIGHT_PAREN, pos, 20'd1, line_cnt);
         "{": add_token(K_LEFT_BRACE, pos, 20'd1, line_cnt);
         "}": add_token(K_RIGHT_BRACE, pos, 20'd1, line_cnt);
         ",": add_token(K_COMMA, pos, 20'd1, line_cnt);
         ".": add_token(K_DOT, pos, 20'd1, line_cnt);
         "-": add_token(K_MINUS, pos, 20'd1, line_cnt);
         "+": add_token(K_PLUS, pos, 20'd1, line_cnt);
         ";": add_token(K_SEMICOLON, pos, 20'd1, line_cnt);
         "*": add_token(K_STAR, pos, 20'd1, line_cnt);
         "!", "=", "<", ">", "/": begin mode = SM_OP; pend_op = c; end
         " ", 8'h0D, 8'h09: ;
         8'h0A: line_inc();
         "\"": mode = SM_STRING;
         default:
            if (digit_c(c)) mode = SM_INT;
            else if (alpha_c(c)) begin mode = SM_IDENT; prefix = {40'd0, c}; end
            else add_token(K_BADCHAR, pos, 20'd1, line_cnt);
      endcase
   endtask

   // works out the tokens one accepted item causes and queues them
   task automatic lex_item(req_item_type it);
      logic [7:0] c;
      logic [19:0] pos;
      c = it.source_byte; pos = byte_pos;
      run_tokens.delete();
      if (it.end_marker) begin
         if (mode == SM_STRING) add_token(K_UNTERM, tok_start, lex_len, line_cnt);
         else flush_lexeme(pos);
         add_token(K_EOF, pos, 20'd0, 16'd0);
         lexer_reset();
      end else begin
         case (mode)
            SM_OP:
               if (pend_op == "/" && c == "/") mode = SM_COMMENT;
               else if (pend_op != "/" && c == "=") begin
                  add_token(single_op_kind(pend_op) + 6'd1, tok_start, 20'd2, line_cnt);
                  mode = SM_IDLE;
               end else begin flush_lexeme(pos); begin_lexeme(c, pos); end
            SM_COMMENT:
               if (c == 8'h0A) begin mode = SM_IDLE; line_inc(); end
            SM_STRING: begin
               lex_len = bump(lex_len);
               if (c == "\"") begin
                  add_token(K_STRING, tok_start, lex_len, line_cnt);
                  mode = SM_IDLE;
               end else if (c == 8'h0A) line_inc();
            end
            SM_INT:
               if (digit_c(c)) lex_len = bump(lex_len);
               else if (c == ".") mode = SM_DOT;
               else begin flush_lexeme(pos); begin_lexeme(c, pos); end
            SM_DOT:
               if (digit_c(c)) begin lex_len = bump(bump(lex_len)); mode = SM_FRAC; end
               else begin flush_lexeme(pos); begin_lexeme(c, pos); end
            SM_FRAC:
               if (digit_c(c)) lex_len = bump(lex_len);
               else begin flush_lexeme(pos); begin_lexeme(c, pos); end
            SM_IDENT:
               if (alpha_c(c) || digit_c(c)) begin
                  if (lex_len < 20'd6) prefix = {prefix[39:0], c};
                  lex_len = bump(lex_len);
               end else begin flush_lexeme(pos); begin_lexeme(c, pos); end
            default: begin_lexeme(c, pos);
         endcase
         byte_pos = pos + 20'd1;
      end
      if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
      foreach (run_tokens[i]) token_queue = {token_queue, run_tokens[i]};
   endtask

   // valid stays high between back-to-back items; it drops only while idling or draining
   task automatic send_byte(logic [7:0] b, bit eom = 1'b0);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{source_byte: b, end_marker: eom};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lex_item('{source_byte: b, end_marker: eom});
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic end_source();
      send_byte(8'($urandom_range(255, 0)), 1'b1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (token_queue.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_item_type exp_tok;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (token_queue.size() == 0) begin
            $error("unexpected token kind=%0d", rsp_data.kind);
            errors++;
         end else begin
            exp_tok = token_queue.pop_front();
            if (rsp_data.kind !== exp_tok.kind) begin
               $error("kind: expected %0d, got %0d", exp_tok.kind, rsp_data.kind); errors++;
            end
            if (rsp_data.start_offset !== exp_tok.start_offset) begin
               $error("start_offset: expected %0d, got %0d",
                      exp_tok.start_offset, rsp_data.start_offset); errors++;
            end
            if (rsp_data.token_length !== exp_tok.token_length) begin
               $error("token_length: expected %0d, got %0d",
                      exp_tok.token_length, rsp_data.token_length); errors++;
            end
            if (rsp_data.line_number !== exp_tok.line_number) begin
               $error("line_number: expected %0d, got %0d",
                      exp_tok.line_number, rsp_data.line_number); errors++;
            end
            if (rsp_data.last_of_run !== exp_tok.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d",
                      exp_tok.last_of_run, rsp_data.last_of_run); errors++;
            end
         end
      end
   end

   // receiver stall, with one long hold-off on request
   initial begin
      int held;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off && !hold_done) begin
            rsp_stall <= 1'b1;
            for (held = 0; held < 60; held++) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_stall <= (recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("lox_lexer_token_scanner: mismatch");
         $finish;
      end
   end

   task automatic test_operators();
      send_text("(){},.-+;*! != = == > >= < <= / x");
      end_source();
   endtask

   task automatic test_literals_and_comments();
      send_text("12.5 7. 3.x\"a\nb\" // note\nand while nil zz9 returns");
      send_text("print\t\r@");
      send_byte(8'hFF);
      send_byte(8'h80);
      send_text("12.");
      end_source();
      send_text("\"open");
      end_source();
      end_source();
   endtask

   function automatic string random_fragment();
      string frags[24] = '{"and ", "class", "else ", "false", "fun ", "for", "if ", "nil ",
         "or", "print ", "return", "super", "this", "true ", "var ", "while",
         "x_1 ", "0.25", "9.", "\"s\"", "// c\n", "\n", "<=", "!"};
      string punct = "!\"(){}*+,-./;<=>";
      string s;
      int r;
      r = $urandom_range(9, 0);
      if (r < 6) return frags[$urandom_range(23, 0)];
      if (r < 8) begin
         s = " ";
         s[0] = punct[$urandom_range(15, 0)];
         return s;
      end
      s = " ";
      s[0] = 8'($urandom_range(255, 0));
      return s;
   endfunction

   task automatic test_random_programs(int n_items);
      int sent;
      string s;
      sent = 0;
      while (sent < n_items) begin
         s = random_fragment();
         send_text(s);
         sent += s.len();
         if ($urandom_range(29, 0) == 0) begin end_source(); sent++; end
      end
      end_source();
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      send_text("(((((((((((((((((((((((())))");
      end_source();
   endtask

   initial begin
      lexer_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_operators();
      test_literals_and_comments();
      drain();
      test_random_programs(8);
      drain();
      send_idle_pct = 87;
      test_random_programs(6);
      drain();
      send_idle_pct = 0; recv_stall_pct = 87;
      test_random_programs(6);
      drain();
      send_idle_pct = 38; recv_stall_pct = 38;
      test_random_programs(6);
      drain();
      send_idle_pct = 0; recv_stall_pct = 0;
      test_backpressure();
      drain();
      if (errors == 0 && token_queue.size() == 0)
         $display("lox_lexer_token_scanner: match");
      else
         $display("lox_lexer_token_scanner: mismatch");
      $finish;
   end

endmodule
